/* design/rbsi_pkg.sv */
// Shared types, widths, register indexes and arithmetic helpers for the ray/box slab test.
package rbsi_pkg;

    localparam int COORD_W   = 32;
    localparam int FRAC_W    = 16;
    localparam int NUM_W     = COORD_W;            // |bound - origin| fits in 32 bits
    localparam int QUO_W     = NUM_W + FRAC_W;     // quotient bits, one per divider stage
    localparam int T_W       = QUO_W + 1;          // signed slab distance
    localparam int DIV_STEPS = QUO_W;
    localparam int NEAR_W    = 16;
    localparam int DIST_W    = 31;
    localparam int FACE_W    = 3;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int LANES     = 6;

    localparam logic [CFG_IDX_W-1:0] REG_BOX_LOW_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_LOW_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_LOW_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_HIGH_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_HIGH_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_HIGH_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT = 3'd6;

    localparam logic [FACE_W-1:0] FACE_NONE = 3'd0;
    localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
    localparam logic [FACE_W-1:0] FACE_POS_X = 3'd2;
    localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;
    localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd4;
    localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;
    localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd6;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] origin_z;
        logic signed [COORD_W-1:0] direction_x;
        logic signed [COORD_W-1:0] direction_y;
        logic signed [COORD_W-1:0] direction_z;
    } ray_t;

    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] hit_distance;
        logic [FACE_W-1:0] face_code;
    } result_t;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [QUO_W-1:0] dq;    // dividend bits shift out the top, quotient bits in the bottom
        logic             neg;
    } div_lane_t;

    typedef struct packed {
        logic [COORD_W-1:0] dm;  // |direction|
        logic               dz;  // direction is zero
        logic               dpos;
    } axis_info_t;

    typedef struct packed {
        div_lane_t  [LANES-1:0] lane;
        axis_info_t [2:0]       ax;
    } div_stage_t;

    typedef struct packed {
        logic signed [T_W-1:0] t_near;
        logic signed [T_W-1:0] t_far;
        logic [FACE_W-1:0]     face;
        logic                  dz;
    } slab_t;

    typedef struct packed {
        logic                  any;
        logic signed [T_W-1:0] tmin;
        logic signed [T_W-1:0] tmax;
        logic [FACE_W-1:0]     face;
    } span_t;

    // One restoring division step.
    function automatic div_lane_t div_step(div_lane_t l, logic [COORD_W-1:0] dm);
        logic [NUM_W:0] trial;
        logic [NUM_W:0] diff;
        logic           ge;
        div_lane_t      r;
        trial = {l.rem, l.dq[QUO_W-1]};
        diff  = trial - {1'b0, dm};
        ge    = (trial >= {1'b0, dm});
        r.rem = ge ? diff[NUM_W-1:0] : trial[NUM_W-1:0];
        r.dq  = {l.dq[QUO_W-2:0], ge};
        r.neg = l.neg;
        return r;
    endfunction

    // Fold one axis into the running entry/exit span.
    function automatic span_t span_merge(span_t acc, slab_t s);
        span_t r;
        r = acc;
        if (!s.dz) begin
            if (!acc.any || s.t_near > acc.tmin) begin
                r.tmin = s.t_near;
                r.face = s.face;
            end
            if (!acc.any || s.t_far < acc.tmax) begin
                r.tmax = s.t_far;
            end
            r.any = 1'b1;
        end
        return r;
    endfunction

endpackage

/* design/ray_box_slab_intersection.sv */
// Top level: pipelined ray against axis-aligned box test (slab method).
//
// Usage:
//  - s_valid/s_ready/s_data carry one ray per transfer (origin and direction,
//    signed Q16.16). m_valid/m_ready/m_data return exactly one result per ray,
//    in order: hit flag, Q16.16 distance saturated to 31 bits, entry face code.
//  - Box corners and near_limit come from the write port (cfg_wr_en,
//    cfg_addr, cfg_wdata); write them only while no ray is in flight.
//  - Pipelined: one bit of each slab quotient is resolved per stage across
//    a 48-stage restoring divider (six lanes, one per slab plane), which
//    sets most of the depth.
//  - Throughput: one ray per cycle, sustained while the receiver keeps m_ready high.
//  - Reset (aresetn low, synchronous) empties the pipeline and loads the box
//    with the unit cube at the origin and near_limit with 66.
//  - When the receiver holds m_ready low with a result waiting, the whole
//    pipeline freezes in place; s_ready drops in the same cycle, so no ray
//    is lost or duplicated. Bubbles are not squeezed out.
module ray_box_slab_intersection (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [rbsi_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [rbsi_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  rbsi_pkg::ray_t                     s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output rbsi_pkg::result_t                  m_data
);

    localparam int NSTG = rbsi_pkg::DIV_STEPS;

    // configuration
    logic signed [rbsi_pkg::COORD_W-1:0] box_low_reg  [3];
    logic signed [rbsi_pkg::COORD_W-1:0] box_high_reg [3];
    logic [rbsi_pkg::NEAR_W-1:0]         near_limit_reg;

    // pipeline
    logic                 adv;
    logic                 in_vld_reg;
    rbsi_pkg::ray_t       ray_reg;
    rbsi_pkg::div_stage_t front_next;
    logic                 div_vld_reg [NSTG+1];
    rbsi_pkg::div_stage_t div_reg     [NSTG+1];
    logic                 p1_vld_reg, p2_vld_reg, p3_vld_reg, p4_vld_reg;
    logic signed [rbsi_pkg::T_W-1:0] t_reg [rbsi_pkg::LANES];
    rbsi_pkg::axis_info_t p1_ax_reg [3];
    rbsi_pkg::slab_t      slab_reg  [3];
    rbsi_pkg::slab_t      slab2_reg;
    rbsi_pkg::span_t      span01_reg;
    rbsi_pkg::span_t      span_reg;
    rbsi_pkg::result_t    res_next;
    logic                 out_vld_reg;
    rbsi_pkg::result_t    out_reg;

    // Whole pipeline moves together unless a finished result is stuck.
    assign adv     = !out_vld_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < 3; a++) begin
                box_low_reg[a]  <= '0;
                box_high_reg[a] <= rbsi_pkg::COORD_W'(1) <<< rbsi_pkg::FRAC_W;
            end
            near_limit_reg <= rbsi_pkg::NEAR_W'(66);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                rbsi_pkg::REG_BOX_LOW_X:  box_low_reg[0]  <= cfg_wdata;
                rbsi_pkg::REG_BOX_LOW_Y:  box_low_reg[1]  <= cfg_wdata;
                rbsi_pkg::REG_BOX_LOW_Z:  box_low_reg[2]  <= cfg_wdata;
                rbsi_pkg::REG_BOX_HIGH_X: box_high_reg[0] <= cfg_wdata;
                rbsi_pkg::REG_BOX_HIGH_Y: box_high_reg[1] <= cfg_wdata;
                rbsi_pkg::REG_BOX_HIGH_Z: box_high_reg[2] <= cfg_wdata;
                rbsi_pkg::REG_NEAR_LIMIT: near_limit_reg  <= cfg_wdata[rbsi_pkg::NEAR_W-1:0];
                default: ;
            endcase
        end
    end

    // Front: numerator/divisor magnitudes and quotient signs.
    always_comb begin
        logic signed [rbsi_pkg::COORD_W-1:0] org [3];
        logic signed [rbsi_pkg::COORD_W-1:0] dir [3];
        logic signed [rbsi_pkg::COORD_W:0]   num;
        logic signed [rbsi_pkg::COORD_W-1:0] bnd;
        logic [rbsi_pkg::COORD_W:0]          mag;
        org[0] = ray_reg.origin_x;    org[1] = ray_reg.origin_y;    org[2] = ray_reg.origin_z;
        dir[0] = ray_reg.direction_x; dir[1] = ray_reg.direction_y; dir[2] = ray_reg.direction_z;
        front_next = '0;
        for (int a = 0; a < 3; a++) begin
            front_next.ax[a].dm   = dir[a][rbsi_pkg::COORD_W-1] ? -dir[a] : dir[a];
            front_next.ax[a].dz   = (dir[a] == '0);
            front_next.ax[a].dpos = !dir[a][rbsi_pkg::COORD_W-1] && (dir[a] != '0);
            for (int b = 0; b < 2; b++) begin
                bnd = (b == 0) ? box_low_reg[a] : box_high_reg[a];
                num = (rbsi_pkg::COORD_W+1)'(bnd) - (rbsi_pkg::COORD_W+1)'(org[a]);
                mag = num[rbsi_pkg::COORD_W] ? -num : num;
                front_next.lane[2*a+b].rem = '0;
                front_next.lane[2*a+b].dq  = {mag[rbsi_pkg::NUM_W-1:0],
                                              {rbsi_pkg::FRAC_W{1'b0}}};
                front_next.lane[2*a+b].neg = num[rbsi_pkg::COORD_W] ^
                                             dir[a][rbsi_pkg::COORD_W-1];
            end
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            for (int k = 0; k <= NSTG; k++) div_vld_reg[k] <= 1'b0;
            p1_vld_reg  <= 1'b0;
            p2_vld_reg  <= 1'b0;
            p3_vld_reg  <= 1'b0;
            p4_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            in_vld_reg     <= s_valid;
            div_vld_reg[0] <= in_vld_reg;
            for (int k = 1; k <= NSTG; k++) div_vld_reg[k] <= div_vld_reg[k-1];
            p1_vld_reg  <= div_vld_reg[NSTG];
            p2_vld_reg  <= p1_vld_reg;
            p3_vld_reg  <= p2_vld_reg;
            p4_vld_reg  <= p3_vld_reg;
            out_vld_reg <= p4_vld_reg;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            ray_reg    <= s_data;
            div_reg[0] <= front_next;
            for (int k = 1; k <= NSTG; k++) begin
                div_reg[k].ax <= div_reg[k-1].ax;
                for (int l = 0; l < rbsi_pkg::LANES; l++) begin
                    div_reg[k].lane[l] <= rbsi_pkg::div_step(div_reg[k-1].lane[l],
                                                             div_reg[k-1].ax[l/2].dm);
                end
            end
            // signed slab distances
            for (int l = 0; l < rbsi_pkg::LANES; l++) begin
                t_reg[l] <= div_reg[NSTG].lane[l].neg
                          ? -$signed({1'b0, div_reg[NSTG].lane[l].dq})
                          :  $signed({1'b0, div_reg[NSTG].lane[l].dq});
            end
            for (int a = 0; a < 3; a++) p1_ax_reg[a] <= div_reg[NSTG].ax[a];
            // order each slab, tag its entry face
            for (int a = 0; a < 3; a++) begin
                slab_reg[a].t_near <= (t_reg[2*a] > t_reg[2*a+1]) ? t_reg[2*a+1] : t_reg[2*a];
                slab_reg[a].t_far  <= (t_reg[2*a] > t_reg[2*a+1]) ? t_reg[2*a] : t_reg[2*a+1];
                slab_reg[a].face   <= rbsi_pkg::FACE_W'(2*a) +
                                      (p1_ax_reg[a].dpos ? rbsi_pkg::FACE_W'(1)
                                                         : rbsi_pkg::FACE_W'(2));
                slab_reg[a].dz     <= p1_ax_reg[a].dz;
            end
            // fold axes x and y, then z
            span01_reg <= rbsi_pkg::span_merge(rbsi_pkg::span_merge('0, slab_reg[0]),
                                               slab_reg[1]);
            slab2_reg  <= slab_reg[2];
            span_reg   <= rbsi_pkg::span_merge(span01_reg, slab2_reg);
            out_reg    <= res_next;
        end
    end

    // Hit decision and saturation
    always_comb begin
        logic signed [rbsi_pkg::T_W-1:0] nr;
        logic signed [rbsi_pkg::T_W-1:0] t;
        nr       = $signed({{(rbsi_pkg::T_W-rbsi_pkg::NEAR_W){1'b0}}, near_limit_reg});
        t        = (span_reg.tmin > nr) ? span_reg.tmin : span_reg.tmax;
        res_next = '0;
        if (!span_reg.any) begin
            res_next.hit          = 1'b1;
            res_next.hit_distance = rbsi_pkg::DIST_MAX;
            res_next.face_code    = rbsi_pkg::FACE_NONE;
        end else if (!(span_reg.tmin > span_reg.tmax) && !(span_reg.tmax < nr)
                     && !(t < nr)) begin
            res_next.hit          = 1'b1;
            res_next.hit_distance = (t > $signed({{(rbsi_pkg::T_W-rbsi_pkg::DIST_W){1'b0}},
                                                 rbsi_pkg::DIST_MAX}))
                                  ? rbsi_pkg::DIST_MAX : t[rbsi_pkg::DIST_W-1:0];
            res_next.face_code    = span_reg.face;
        end
    end

endmodule

/* dv/tb_ray_box_slab_intersection.sv */
// Self-checking testbench for the ray/box slab intersection block.
module tb_ray_box_slab_intersection;
    import rbsi_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 80;    // longer than the pipeline

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    ray_t                 s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    result_t              m_data;

    ray_box_slab_intersection uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Shadow copy of the box registers.
    logic signed [COORD_W-1:0] box_lo [3];
    logic signed [COORD_W-1:0] box_hi [3];
    logic [NEAR_W-1:0]         near_lim;

    ray_t    ray_queue [$];
    result_t hit_queue [$];
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      mismatches = 0;
    int      rays_sent = 0;
    int      results_seen = 0;
    int      hits_seen = 0;
    int      stall_count = 0;
    bit      timed_out = 1'b0;

    // Exact truncating quotient (bound - origin) * 2^16 / dir, 49-bit signed.
    function automatic longint slab_distance(longint bound, longint orig, longint dir);
        longint num;
        bit     neg;
        longint unsigned nm, dm;
        num = bound - orig;
        neg = (num < 0) != (dir < 0);
        nm  = (num < 0) ? -num : num;
        dm  = (dir < 0) ? -dir : dir;
        if (dm == 0) return 0;
        nm = (nm << FRAC_W) / dm;
        return neg ? -longint'(nm) : longint'(nm);
    endfunction

    function automatic result_t predict_hit(ray_t r);
        result_t res;
        bit      any;
        longint  tmin, tmax, t1, t2, tt, near_v;
        logic [FACE_W-1:0] face;
        longint  o [3];
        longint  d [3];
        any = 0; tmin = 0; tmax = 0; face = FACE_NONE;
        near_v = near_lim;
        o[0] = r.origin_x; o[1] = r.origin_y; o[2] = r.origin_z;
        d[0] = r.direction_x; d[1] = r.direction_y; d[2] = r.direction_z;
        res = '0;
        for (int a = 0; a < 3; a++) begin
            if (d[a] == 0) continue;
            t1 = slab_distance(box_lo[a], o[a], d[a]);
            t2 = slab_distance(box_hi[a], o[a], d[a]);
            if (t1 > t2) begin
                tt = t1; t1 = t2; t2 = tt;
            end
            if (!any || t1 > tmin) begin
                tmin = t1;
                face = (d[a] > 0) ? FACE_W'(2 * a + 1) : FACE_W'(2 * a + 2);
            end
            if (!any || t2 < tmax) tmax = t2;
            any = 1;
        end
        if (!any) begin
            res.hit = 1'b1; res.hit_distance = DIST_MAX; res.face_code = FACE_NONE;
            return res;
        end
        if (tmin > tmax || tmax < near_v) return res;
        tt = (tmin > near_v) ? tmin : tmax;
        if (tt < near_v) return res;
        if (tt > longint'(DIST_MAX)) tt = DIST_MAX;
        if (tt < 0) tt = 0;
        res.hit = 1'b1;
        res.hit_distance = tt[DIST_W-1:0];
        res.face_code = face;
        return res;
    endfunction

    // Driver: valid held with stable payload until the transfer happens.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_ready) begin
                if (s_valid) begin
                    hit_queue.push_back(predict_hit(s_data));
                    rays_sent++;
                end
                if (ray_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_data  <= ray_queue.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: compare each result transfer with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (m_data.hit) hits_seen++;
                if (hit_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result %p", m_data);
                end else begin
                    result_t exp_res;
                    exp_res = hit_queue.pop_front();
                    if (m_data.hit !== exp_res.hit
                            || m_data.hit_distance !== exp_res.hit_distance
                            || m_data.face_code !== exp_res.face_code) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: result %0d expected %p got %p",
                                     results_seen, exp_res, m_data);
                    end
                end
            end
            // Watchdog: cycles with no transfer on either side.
            if ((s_valid && s_ready) || (m_valid && m_ready)) stall_count <= 0;
            else stall_count <= stall_count + 1;
        end
    end

    always @(posedge aclk) begin
        if (stall_count >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("ERROR: watchdog expired, %0d results outstanding", hit_queue.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Write enable stays high across back-to-back writes; set_box drops it.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_addr  <= idx;
        cfg_wdata <= val;
        cfg_wr_en <= 1'b1;
        @(posedge aclk);
        case (idx)
            REG_BOX_LOW_X:  box_lo[0] = val;
            REG_BOX_LOW_Y:  box_lo[1] = val;
            REG_BOX_LOW_Z:  box_lo[2] = val;
            REG_BOX_HIGH_X: box_hi[0] = val;
            REG_BOX_HIGH_Y: box_hi[1] = val;
            REG_BOX_HIGH_Z: box_hi[2] = val;
            default:        near_lim  = val[NEAR_W-1:0];
        endcase
    endtask

    // Checks run after the edge's updates settle, so a ray just popped
    // by the driver is never missed.
    task automatic wait_idle();
        while (ray_queue.size() > 0 || s_valid || hit_queue.size() > 0) begin
            @(posedge aclk);
            #1;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_box(logic [CFG_W-1:0] lx, ly, lz, hx, hy, hz,
                           logic [NEAR_W-1:0] nl);
        write_reg(REG_BOX_LOW_X, lx);
        write_reg(REG_BOX_LOW_Y, ly);
        write_reg(REG_BOX_LOW_Z, lz);
        write_reg(REG_BOX_HIGH_X, hx);
        write_reg(REG_BOX_HIGH_Y, hy);
        write_reg(REG_BOX_HIGH_Z, hz);
        write_reg(REG_NEAR_LIMIT, {16'd0, nl});
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coord(int span_bits);
        logic [31:0] v;
        case ($urandom_range(9))
            0:       v = $urandom;
            1:       v = 32'h8000_0000;
            2:       v = 32'h7fff_ffff;
            3:       v = 32'h0000_0000;
            default: v = 32'($signed($urandom) >>> (32 - span_bits));
        endcase
        return v;
    endfunction

    // Random ray: about half aimed toward a box around the origin, some pure noise.
    function automatic ray_t random_ray();
        ray_t r;
        if ($urandom_range(9) == 0) begin
            r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        end else begin
            r.origin_x = rand_coord(20);
            r.origin_y = rand_coord(20);
            r.origin_z = rand_coord(20);
            r.direction_x = ($urandom_range(7) == 0) ? 32'd0 : rand_coord(18);
            r.direction_y = ($urandom_range(7) == 0) ? 32'd0 : rand_coord(18);
            r.direction_z = ($urandom_range(7) == 0) ? 32'd0 : rand_coord(18);
            // aim roughly toward the origin so many rays hit
            if ($urandom_range(1)) begin
                r.direction_x = -(r.origin_x >>> 2);
                r.direction_y = -(r.origin_y >>> 2) + $signed(12'($urandom));
                r.direction_z = -(r.origin_z >>> 2) + $signed(12'($urandom));
            end
        end
        return r;
    endfunction

    task automatic run_random(int count);
        for (int i = 0; i < count; i++) ray_queue.push_back(random_ray());
        wait_idle();
    endtask

    localparam logic [31:0] ONE = 32'h0001_0000;

    initial begin
        box_lo = '{0, 0, 0};
        box_hi = '{ONE, ONE, ONE};
        near_lim = 16'd66;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rays against the reset unit cube.
        send_idle_pct = 0; recv_idle_pct = 0;
        ray_queue.push_back('{-ONE, 32'h8000, 32'h8000, ONE, 0, 0});           // -x face
        ray_queue.push_back('{2 * ONE, 32'h8000, 32'h8000, -ONE, 0, 0});       // +x face
        ray_queue.push_back('{32'h8000, -ONE, 32'h8000, 0, ONE, 0});           // -y face
        ray_queue.push_back('{32'h8000, 3 * ONE, 32'h8000, 0, -ONE, 0});       // +y face
        ray_queue.push_back('{32'h8000, 32'h8000, -ONE, 0, 0, 32'h4000});      // -z face
        ray_queue.push_back('{32'h8000, 32'h8000, 5 * ONE, 0, 0, -ONE});       // +z face
        ray_queue.push_back('{32'h8000, 32'h8000, 32'h8000, ONE, ONE, ONE});   // start inside
        ray_queue.push_back('{32'h8000, 32'h8000, 32'h8000, 0, 0, 0});         // all parallel
        ray_queue.push_back('{5 * ONE, 32'h8000, 32'h8000, 0, ONE, 0});        // parallel outside
        ray_queue.push_back('{-ONE, -ONE, -ONE, -ONE, -ONE, -ONE});            // pointing away
        ray_queue.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
        ray_queue.push_back('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                              32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        ray_queue.push_back('{32'h8000_0000, 32'h8000, 32'h8000, 32'h1, 0, 0}); // saturates
        ray_queue.push_back('{-ONE, -ONE, -ONE, 32'h1, 32'h1, 32'h1});
        ray_queue.push_back('{ONE, 32'h8000, 32'h8000, ONE, 0, 0});             // on the exit plane
        ray_queue.push_back('{32'hffff_ffff, 0, 0, ONE, ONE, ONE});
        wait_idle();

        // Inverted box and extreme near limit.
        set_box(ONE, ONE, ONE, 0, 0, 0, 16'hffff);
        ray_queue.push_back('{-ONE, 32'h8000, 32'h8000, ONE, 0, 0});
        ray_queue.push_back('{32'h8000, 32'h8000, 32'h8000, ONE, -ONE, ONE});
        wait_idle();

        // Phase 1: sender idles 28%, receiver 70%, moderate box.
        send_idle_pct = 28; recv_idle_pct = 70;
        set_box(-4 * ONE, -3 * ONE, -2 * ONE, 4 * ONE, 2 * ONE, 5 * ONE, 16'd66);
        run_random(550);

        // Phase 2: swapped idling; extreme box with zero near limit, then a thin box with a large near limit.
        send_idle_pct = 70; recv_idle_pct = 28;
        set_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'd0);
        run_random(250);
        set_box(-ONE, 2 * ONE, -8 * ONE, ONE, 3 * ONE, -7 * ONE, 16'h8000);
        run_random(300);

        // Phase 3: no idling, random box.
        send_idle_pct = 0; recv_idle_pct = 0;
        set_box(-($urandom_range(1 << 20)), -($urandom_range(1 << 20)),
                -($urandom_range(1 << 20)), $urandom_range(1 << 20),
                $urandom_range(1 << 20), $urandom_range(1 << 20), 16'($urandom));
        run_random(600);

        $display("Summary: %0d rays checked, %0d results, %0d hits, six box settings",
                 rays_sent, results_seen, hits_seen);
        if (mismatches == 0 && hit_queue.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Mismatches: %0d, left over: %0d", mismatches, hit_queue.size());
            $display("Verification failed");
        end
        $finish;
    end

endmodule
